// File: hdl/dcbp_pkg.sv
package dcbp_pkg;

  // Field widths.
  localparam int unsigned VoltW  = 14;
  localparam int unsigned DutyW  = 7;
  // 90 * 16383 fits in 21 bits.
  localparam int unsigned DvdW   = 21;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [DutyW-1:0] DutyMax = 7'd100;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_RELAY_ON   = 3'd0,
    REG_UNDER_MARG = 3'd1,
    REG_OVER_TRIP  = 3'd2,
    REG_REGEN_ON   = 3'd3,
    REG_REGEN_OFF  = 3'd4,
    REG_REGEN_REF  = 3'd5
  } cfg_idx_e;

  // Trip causes as reported on the result channel.
  typedef enum logic [1:0] {
    CAUSE_NONE  = 2'd0,
    CAUSE_UNDER = 2'd1,
    CAUSE_OVER  = 2'd2
  } cause_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_DONE
  } st_e;

  typedef struct packed {
    logic [VoltW-1:0] relay_on;
    logic [VoltW-1:0] under_margin;
    logic [VoltW-1:0] over_trip;
    logic [VoltW-1:0] brake_on;
    logic [VoltW-1:0] brake_off;
    logic [VoltW-1:0] regen_ref;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [DvdW-1:0]  dividend;
    logic [VoltW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DutyW-1:0] duty;
  } div_res_t;

  typedef struct packed {
    logic             relay;
    cause_e           cause;
    logic             chop;
    logic [DutyW-1:0] duty;
  } res_t;

  // 90 * ref as a sum of shifts (64 + 16 + 8 + 2).
  function automatic logic [DvdW-1:0] scale_ref(input logic [VoltW-1:0] r);
    logic [DvdW-1:0] rx;
    rx = {{(DvdW-VoltW){1'b0}}, r};
    return (rx << 6) + (rx << 4) + (rx << 3) + (rx << 1);
  endfunction

endpackage

// File: hdl/dcbp_if.sv
// Sample channel.
interface dcbp_in_if import dcbp_pkg::*;;
  logic             valid;
  logic             ready;
  logic [VoltW-1:0] bus_voltage;

  modport source (output valid, output bus_voltage, input ready);
  modport sink (input valid, input bus_voltage, output ready);
endinterface

// Result channel.
interface dcbp_out_if import dcbp_pkg::*;;
  logic             valid;
  logic             ready;
  logic             relay_closed;
  logic             trip;
  logic [1:0]       trip_cause;
  logic             chopper_on;
  logic [DutyW-1:0] chopper_duty;

  modport source (output valid, output relay_closed, output trip, output trip_cause,
                  output chopper_on, output chopper_duty, input ready);
  modport sink (input valid, input relay_closed, input trip, input trip_cause,
                input chopper_on, input chopper_duty, output ready);
endinterface

// Configuration write channel.
interface dcbp_cfg_if import dcbp_pkg::*;;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [VoltW-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: hdl/dc_bus_protection_regen_chopper.sv
// DC bus protection and regenerative brake chopper.
//
// in_i carries one bus voltage sample per beat; out_o returns one result beat
// per sample with relay state, trip flag and cause, and chopper state and duty.
// cfg_i writes the six level registers by index; it is always ready and must
// only be used while no sample is in flight.
//
// A sample that trips, or that does not exceed the regen start level, is
// evaluated into a pending result that is then committed to the output
// register. A sample above the start level first runs the bit-serial duty
// divider, 7 quotient bits at one per cycle. One sample is worked on at a
// time; the next is taken in the cycle after the previous result enters
// the output register.
//
// Reset opens the relay, turns the chopper off with duty 0 and loads the
// default levels. When the receiver stalls, the result waits in the output
// register, a following sample is still accepted and worked on, and it then
// waits for the output register to drain.
module dc_bus_protection_regen_chopper import dcbp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  dcbp_in_if.sink     in_i,
  dcbp_out_if.source  out_o,
  dcbp_cfg_if.sink    cfg_i
);

  cfg_t             cfg;
  div_req_t         div_req;
  div_res_t         div_res;
  st_e              state_q, state_d;
  logic [VoltW-1:0] v_q;
  logic             relay_q, chop_q;
  logic [DutyW-1:0] duty_q;
  res_t             p_q, p_d;
  res_t             out_q;
  logic             out_valid_q;
  logic             commit;
  logic             relay_nx, under_hit, over_hit, start_hit, end_hit;

  dcbp_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  dcbp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .res_o  (div_res)
  );

  // Level compares on the held sample.
  assign relay_nx  = relay_q || (v_q > cfg.relay_on);
  assign under_hit = relay_q &&
                     (({1'b0, v_q} + {1'b0, cfg.under_margin}) < {1'b0, cfg.relay_on});
  assign over_hit  = v_q > cfg.over_trip;
  assign start_hit = v_q > cfg.brake_on;
  assign end_hit   = v_q < cfg.brake_off;

  // Sequencer: next state, pending result and handshake.
  always_comb begin
    state_d          = state_q;
    p_d              = p_q;
    div_req.start    = 1'b0;
    div_req.dividend = scale_ref(cfg.regen_ref);
    div_req.divisor  = v_q;
    commit           = 1'b0;
    in_i.ready       = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        p_d.relay = relay_nx;
        p_d.cause = CAUSE_NONE;
        p_d.chop  = chop_q;
        p_d.duty  = duty_q;
        state_d   = ST_DONE;
        if (under_hit) begin
          p_d.cause = CAUSE_UNDER;
        end else if (over_hit) begin
          p_d.cause = CAUSE_OVER;
        end else if (start_hit) begin
          div_req.start = 1'b1;
          state_d       = ST_DIV;
        end else if (chop_q && end_hit) begin
          p_d.chop = 1'b0;
          p_d.duty = '0;
        end
      end
      ST_DIV: begin
        if (div_res.done) begin
          p_d.chop = !end_hit;
          p_d.duty = end_hit ? '0 : div_res.duty;
          state_d  = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          commit  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Block state moves on when a result is committed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      relay_q     <= 1'b0;
      chop_q      <= 1'b0;
      duty_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (commit) begin
        relay_q     <= p_q.relay;
        chop_q      <= p_q.chop;
        duty_q      <= p_q.duty;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      v_q <= in_i.bus_voltage;
    end
    p_q <= p_d;
    if (commit) begin
      out_q <= p_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.relay_closed = out_q.relay;
  assign out_o.trip         = out_q.cause != CAUSE_NONE;
  assign out_o.trip_cause   = out_q.cause;
  assign out_o.chopper_on   = out_q.chop;
  assign out_o.chopper_duty = out_q.duty;

  // Once closed, the relay stays closed.
  a_relay_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    relay_q |=> relay_q)
    else $error("relay opened after closing");

  // Only the three defined trip codes appear on a valid result.
  a_cause_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_q.cause == CAUSE_NONE) ||
                     (out_q.cause == CAUSE_UNDER) || (out_q.cause == CAUSE_OVER)))
    else $error("undefined trip cause");

  // Duty never exceeds full scale.
  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.duty <= DutyMax))
    else $error("duty above full scale");

  // The divider finishes only for a sample that launched it.
  a_div_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_res.done |-> (state_q == ST_DIV))
    else $error("divider finished outside a duty computation");

endmodule

// File: hdl/dcbp_cfg.sv
module dcbp_cfg import dcbp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  dcbp_cfg_if.sink   cfg_i,
  output cfg_t       cfg_o
);

  cfg_t cfg_q;

  // Writes are always taken; unknown indexes are dropped.
  assign cfg_i.ready = 1'b1;
  assign cfg_o = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.relay_on     <= 14'd1860;
      cfg_q.under_margin <= 14'd200;
      cfg_q.over_trip    <= 14'd4045;
      cfg_q.brake_on     <= 14'd3734;
      cfg_q.brake_off    <= 14'd3578;
      cfg_q.regen_ref    <= 14'd3300;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_RELAY_ON:   cfg_q.relay_on     <= cfg_i.data;
        REG_UNDER_MARG: cfg_q.under_margin <= cfg_i.data;
        REG_OVER_TRIP:  cfg_q.over_trip    <= cfg_i.data;
        REG_REGEN_ON:   cfg_q.brake_on     <= cfg_i.data;
        REG_REGEN_OFF:  cfg_q.brake_off    <= cfg_i.data;
        REG_REGEN_REF:  cfg_q.regen_ref    <= cfg_i.data;
        default: ;
      endcase
    end
  end

endmodule

// File: hdl/dcbp_div.sv
module dcbp_div import dcbp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_res_t res_o
);

  logic [DvdW-1:0]  rem_q, rem_d;
  logic [DvdW-1:0]  dvs_q, dvs_d;
  logic [DutyW-1:0] quot_q, quot_d;
  logic [2:0]       cnt_q;
  logic             busy_q, done_q, sat_q;
  logic             fits;

  // One quotient bit per cycle: the divisor shifts right past the remainder.
  assign fits   = rem_q >= dvs_q;
  assign rem_d  = fits ? rem_q - dvs_q : rem_q;
  assign dvs_d  = dvs_q >> 1;
  assign quot_d = {quot_q[DutyW-2:0], fits};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (cnt_q == 3'd0);
      if (req_i.start) begin
        busy_q <= 1'b1;
      end else if (busy_q && (cnt_q == 3'd0)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Datapath registers; a quotient of 128 or more saturates at once.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= req_i.dividend;
      dvs_q  <= {1'b0, req_i.divisor, 6'b0};
      sat_q  <= req_i.dividend >= {req_i.divisor, 7'b0};
      quot_q <= '0;
      cnt_q  <= 3'd6;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      dvs_q  <= dvs_d;
      quot_q <= quot_d;
      cnt_q  <= cnt_q - 3'd1;
    end
  end

  assign res_o.done = done_q;
  assign res_o.duty = (sat_q || (quot_q > DutyMax)) ? DutyMax : quot_q;

endmodule

// File: sim/dcbp_checker.sv
// Watches the sample, result and configuration channels of the bus protection
// block. It keeps its own copy of the levels and of the relay and chopper
// state, works out the status that each accepted sample must give and
// compares it with the result beats in order.
module dcbp_checker import dcbp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  dcbp_in_if          sample_i,
  dcbp_out_if         status_i,
  dcbp_cfg_if         cfg_i,
  output int unsigned err_cnt_o,
  output int unsigned pending_o
);

  localparam int unsigned DutyScale = 90;
  localparam int unsigned ShownErrs = 10;

  cfg_t             lvl_q;
  logic             relay_q;
  logic             chop_q;
  logic [DutyW-1:0] duty_q;
  res_t             status_due_q[$];

  // Status after one sample; the relay, chopper and duty state move on with it.
  function automatic res_t judge_sample(input logic [VoltW-1:0] v);
    int          under_lvl;
    int unsigned quot;
    cause_e      cause;
    cause = CAUSE_NONE;
    if (!relay_q) begin
      // The closing sample is never checked for undervoltage.
      if (v > lvl_q.relay_on) relay_q = 1'b1;
    end else begin
      // A margin above the relay level gives a negative threshold: no trip.
      under_lvl = int'(lvl_q.relay_on) - int'(lvl_q.under_margin);
      if (int'(v) < under_lvl) cause = CAUSE_UNDER;
    end
    if (cause == CAUSE_NONE && v > lvl_q.over_trip) cause = CAUSE_OVER;
    // A trip leaves the chopper as it stands.
    if (cause == CAUSE_NONE) begin
      if (v > lvl_q.brake_on) begin
        chop_q = 1'b1;
        quot = (DutyScale * int'(lvl_q.regen_ref)) / int'(v);
        duty_q = (quot > int'(DutyMax)) ? DutyMax : quot[DutyW-1:0];
      end
      // With the start level under the end level this may undo the turn-on.
      if (chop_q && v < lvl_q.brake_off) begin
        chop_q = 1'b0;
        duty_q = '0;
      end
    end
    return '{relay: relay_q, cause: cause, chop: chop_q, duty: duty_q};
  endfunction

  // Results are checked before the sample of the same edge is predicted.
  always @(posedge clk_i or negedge rst_ni) begin : watch_beats
    res_t want;
    res_t got;
    if (!rst_ni) begin
      lvl_q = '{relay_on: 14'd1860, under_margin: 14'd200, over_trip: 14'd4045,
                brake_on: 14'd3734, brake_off: 14'd3578, regen_ref: 14'd3300};
      relay_q = 1'b0;
      chop_q = 1'b0;
      duty_q = '0;
      status_due_q.delete();
      err_cnt_o = 0;
      pending_o = 0;
    end else begin
      if (status_i.valid && status_i.ready) begin
        got = '{relay: status_i.relay_closed, cause: cause_e'(status_i.trip_cause),
                chop: status_i.chopper_on, duty: status_i.chopper_duty};
        if (status_due_q.size() == 0) begin
          err_cnt_o++;
          if (err_cnt_o <= ShownErrs) begin
            $display("%0t: result beat with no sample pending:", $time);
            $display("%0t:   relay %0b trip %0b cause %0d chop %0b duty %0d",
                     $time, got.relay, status_i.trip, got.cause, got.chop, got.duty);
          end
        end else begin
          want = status_due_q.pop_front();
          if ({got, status_i.trip} !== {want, want.cause != CAUSE_NONE}) begin
            err_cnt_o++;
            if (err_cnt_o <= ShownErrs) begin
              $display("%0t: status mismatch, expected relay %0b trip %0b cause %0d chop %0b duty %0d",
                       $time, want.relay, want.cause != CAUSE_NONE, want.cause, want.chop,
                       want.duty);
              $display("%0t:                  got relay %0b trip %0b cause %0d chop %0b duty %0d",
                       $time, got.relay, status_i.trip, got.cause, got.chop, got.duty);
            end
          end
        end
      end
      if (sample_i.valid && sample_i.ready) begin
        status_due_q.push_back(judge_sample(sample_i.bus_voltage));
      end
      // Writes to the spare indexes are dropped.
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          REG_RELAY_ON:   lvl_q.relay_on = cfg_i.data;
          REG_UNDER_MARG: lvl_q.under_margin = cfg_i.data;
          REG_OVER_TRIP:  lvl_q.over_trip = cfg_i.data;
          REG_REGEN_ON:   lvl_q.brake_on = cfg_i.data;
          REG_REGEN_OFF:  lvl_q.brake_off = cfg_i.data;
          REG_REGEN_REF:  lvl_q.regen_ref = cfg_i.data;
          default: ;
        endcase
      end
      pending_o = status_due_q.size();
    end
  end

endmodule

// File: sim/tb_dc_bus_protection_regen_chopper.sv
module tb_dc_bus_protection_regen_chopper;
  import dcbp_pkg::*;

  localparam logic [CfgIdxW-1:0] RegSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSpareHi = 3'd7;
  localparam logic [VoltW-1:0]   VoltTop    = 14'h3FFF;
  localparam int unsigned        RandPhases = 6;
  localparam int unsigned        PhaseItems = 125;
  localparam int unsigned        SettleCyc  = 16;

  logic             clk_i;
  logic             rst_ni;
  int unsigned      err_cnt;
  int unsigned      pending_cnt;
  int unsigned      burst_left;
  logic [VoltW-1:0] plan_q[$];

  dcbp_in_if  sample_if ();
  dcbp_out_if status_if ();
  dcbp_cfg_if cfg_if ();

  dc_bus_protection_regen_chopper uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (sample_if),
    .out_o  (status_if),
    .cfg_i  (cfg_if)
  );

  dcbp_checker u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .sample_i  (sample_if),
    .status_i  (status_if),
    .cfg_i     (cfg_if),
    .err_cnt_o (err_cnt),
    .pending_o (pending_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Guard against a hung handshake.
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // The result side stalls in randomly chosen modes.
  initial begin : result_stall
    int unsigned stall_mode;
    status_if.ready <= 1'b0;
    forever begin
      stall_mode = $urandom_range(0, 3);
      repeat (64) begin
        @(negedge clk_i);
        case (stall_mode)
          0, 1: status_if.ready <= 1'b1;
          2: status_if.ready <= 1'($urandom_range(0, 1));
          default: status_if.ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // Hold one sample beat until the block takes it.
  task automatic send_sample(input logic [VoltW-1:0] v);
    @(negedge clk_i);
    sample_if.valid <= 1'b1;
    sample_if.bus_voltage <= v;
    do @(posedge clk_i); while (!sample_if.ready);
  endtask

  task automatic idle_for(input int unsigned n);
    @(negedge clk_i);
    sample_if.valid <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [VoltW-1:0] val);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Send the planned samples in bursts, then wait for every status beat.
  task automatic play_samples();
    while (plan_q.size() != 0) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 14));
      end
      send_sample(plan_q.pop_front());
      burst_left--;
    end
    idle_for(1);
    do @(negedge clk_i); while (pending_cnt != 0);
  endtask

  // Mostly samples close to one of the thresholds or inside the hysteresis band.
  function automatic logic [VoltW-1:0] pick_volt(input cfg_t l);
    int v;
    int jit;
    jit = int'($urandom_range(0, 8)) - 4;
    case ($urandom_range(0, 9))
      0, 1, 2: v = int'($urandom_range(0, 16383));
      3: v = int'(l.relay_on) - int'(l.under_margin) + jit;
      4: v = int'(l.relay_on) + jit;
      5: v = int'(l.over_trip) + jit;
      6: v = int'(l.brake_on) + jit;
      7: v = int'(l.brake_off) + jit;
      default: v = int'($urandom_range(l.brake_off, l.brake_on));
    endcase
    if (v < 0) v = 0;
    if (v > int'(VoltTop)) v = int'(VoltTop);
    return v[VoltW-1:0];
  endfunction

  // One random setting of the levels followed by a run of samples.
  task automatic random_phase(input int unsigned n_items);
    cfg_t        l;
    logic [VoltW-1:0] tmp;
    if ($urandom_range(0, 3) == 0) begin
      l = '{relay_on: VoltW'($urandom_range(0, 16383)),
            under_margin: VoltW'($urandom_range(0, 16383)),
            over_trip: VoltW'($urandom_range(0, 16383)),
            brake_on: VoltW'($urandom_range(0, 16383)),
            brake_off: VoltW'($urandom_range(0, 16383)),
            regen_ref: VoltW'($urandom_range(0, 16383))};
    end else begin
      l.relay_on = VoltW'($urandom_range(1000, 3000));
      l.under_margin = VoltW'($urandom_range(0, 3500));
      l.brake_off = VoltW'($urandom_range(l.relay_on, 12000));
      l.brake_on = l.brake_off + VoltW'($urandom_range(0, 800));
      l.over_trip = l.brake_on + VoltW'($urandom_range(0, 3000));
      l.regen_ref = VoltW'($urandom_range(2000, 16383));
      // Now and then the start level sits under the end level.
      if ($urandom_range(0, 4) == 0) begin
        tmp = l.brake_on;
        l.brake_on = l.brake_off;
        l.brake_off = tmp;
      end
    end
    write_reg(REG_RELAY_ON, l.relay_on);
    write_reg(REG_UNDER_MARG, l.under_margin);
    write_reg(REG_OVER_TRIP, l.over_trip);
    write_reg(REG_REGEN_ON, l.brake_on);
    write_reg(REG_REGEN_OFF, l.brake_off);
    write_reg(REG_REGEN_REF, l.regen_ref);
    if ($urandom_range(0, 1) == 0) write_reg(RegSpareHi, VoltW'($urandom_range(0, 16383)));
    repeat (n_items) plan_q.push_back(pick_volt(l));
    play_samples();
  endtask

  initial begin : stimulus
    int unsigned ph;
    rst_ni = 1'b0;
    sample_if.valid <= 1'b0;
    sample_if.bus_voltage <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= REG_RELAY_ON;
    cfg_if.data <= '0;
    burst_left = 0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // Default levels: the relay closes on a sample that also trips high, then
    // undervoltage edges, chopper turn-on, hold in the band, a high trip, turn-off, then start and trip edges.
    plan_q = '{14'd0, 14'd1860, VoltTop, 14'd1000, 14'd1659, 14'd1660, 14'd3735,
               14'd3600, 14'd4046, 14'd3577, 14'd3734, 14'd4045};
    play_samples();

    // Margin above the relay level, no overvoltage, start level under end level.
    write_reg(REG_RELAY_ON, 14'd100);
    write_reg(REG_UNDER_MARG, VoltTop);
    write_reg(REG_OVER_TRIP, VoltTop);
    write_reg(REG_REGEN_ON, 14'd0);
    write_reg(REG_REGEN_OFF, VoltTop);
    write_reg(REG_REGEN_REF, VoltTop);
    write_reg(RegSpareLo, 14'd0);
    write_reg(RegSpareHi, VoltTop);
    plan_q = '{14'd0, 14'd1, VoltTop, 14'd16382};
    play_samples();

    // Zero levels: duty saturation and truncation, and a zero sample.
    write_reg(REG_REGEN_OFF, 14'd0);
    write_reg(REG_RELAY_ON, 14'd0);
    write_reg(REG_UNDER_MARG, 14'd0);
    plan_q = '{14'd1, 14'd14745, 14'd0, VoltTop};
    play_samples();

    // Zero reference gives a running chopper at zero duty.
    write_reg(REG_REGEN_REF, 14'd0);
    plan_q = '{14'd5, VoltTop};
    play_samples();

    // Overvoltage level at zero.
    write_reg(REG_OVER_TRIP, 14'd0);
    plan_q = '{14'd0, 14'd1};
    play_samples();

    for (ph = 0; ph < RandPhases; ph++) random_phase(PhaseItems);

    repeat (SettleCyc) @(negedge clk_i);
    if (err_cnt + pending_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: dc_bus_protection_regen_chopper.f
hdl/dcbp_pkg.sv
hdl/dcbp_if.sv
hdl/dcbp_cfg.sv
hdl/dcbp_div.sv
hdl/dc_bus_protection_regen_chopper.sv
sim/dcbp_checker.sv
sim/tb_dc_bus_protection_regen_chopper.sv
